### rtl/tcle_pkg.sv
// shared types and constants of the text console line editor
// no dependencies; used by the controller, the datapath and the top level
`timescale 1ns / 1ps

package tcle_pkg;

    // function codes of an input beat
    localparam logic [2:0] FUNC_WRITE   = 3'd0;
    localparam logic [2:0] FUNC_BKSP    = 3'd1;
    localparam logic [2:0] FUNC_CLEAR   = 3'd2;
    localparam logic [2:0] FUNC_INSERT  = 3'd3;
    localparam logic [2:0] FUNC_DELETE  = 3'd4;
    localparam logic [2:0] FUNC_ACCEPT  = 3'd5;
    localparam logic [2:0] FUNC_READ    = 3'd6;

    // configuration register indexes
    localparam logic [1:0] REG_COLUMNS  = 2'd0;
    localparam logic [1:0] REG_ROWS     = 2'd1;
    localparam logic [1:0] REG_LIMIT    = 2'd2;

    // character codes
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_NUL     = 8'h00;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic clr_init;
        logic clr_step;
        logic shift_init;
        logic shift_rd;
        logic shift_wr;
        logic finish;
        logic rd_issue;
        logic capture;
    } tcle_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic [2:0] func;
        logic       ign;
        logic       clr_last;
        logic       shift_more;
        logic       out_free;
    } tcle_status_t;

endpackage

### rtl/tcle_ram.sv
// generic single write port ram with a registered read port
// no dependencies
`timescale 1ns / 1ps

module tcle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/tcle_ctrl.sv
// controller state machine of the text console line editor
// depends on tcle_pkg for the command and status structs
`timescale 1ns / 1ps

module tcle_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  tcle_pkg::tcle_status_t status,
    output tcle_pkg::tcle_cmd_t    cmd
);

    typedef enum logic [7:0] {
        ST_CLEAR    = 8'b0000_0001,
        ST_IDLE     = 8'b0000_0010,
        ST_DISPATCH = 8'b0000_0100,
        ST_SHIFT_RD = 8'b0000_1000,
        ST_SHIFT_WR = 8'b0001_0000,
        ST_FINISH   = 8'b0010_0000,
        ST_READ     = 8'b0100_0000,
        ST_CAPTURE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   item_reg, item_next;

    // state and item-in-flight flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            item_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            item_reg  <= item_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = item_reg ? ST_READ : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    item_next  = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (status.func == tcle_pkg::FUNC_CLEAR)
                begin
                    cmd.clr_init = 1'b1;
                    state_next   = ST_CLEAR;
                end
                else if ((status.func == tcle_pkg::FUNC_INSERT ||
                          status.func == tcle_pkg::FUNC_DELETE) && !status.ign)
                begin
                    cmd.shift_init = 1'b1;
                    state_next     = ST_SHIFT_RD;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SHIFT_RD:
            begin
                if (status.shift_more)
                begin
                    cmd.shift_rd = 1'b1;
                    state_next   = ST_SHIFT_WR;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = ST_SHIFT_RD;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_CAPTURE;
            end
            ST_CAPTURE:
            begin
                if (status.out_free)
                begin
                    cmd.capture = 1'b1;
                    item_next   = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/tcle_dpath.sv
// datapath of the text console line editor: cursor, line registers, stores
// depends on tcle_pkg and tcle_ram
`timescale 1ns / 1ps

module tcle_dpath #(
    parameter int MAX_COLS = 80,
    parameter int MAX_ROWS = 32,
    parameter int MAX_LINE = 128
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tcle_pkg::tcle_cmd_t    cmd,
    output tcle_pkg::tcle_status_t status,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_wdata,
    input  logic [2:0]            func,
    input  logic [7:0]            char_code,
    input  logic [6:0]            read_column,
    input  logic [4:0]            read_row,
    input  logic [6:0]            read_index,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [6:0]            cursor_column,
    output logic [4:0]            cursor_row,
    output logic [7:0]            line_length,
    output logic [7:0]            edit_position,
    output logic [7:0]            cell_char,
    output logic [7:0]            line_char,
    output logic                  ignored
);

    localparam int GDEPTH = MAX_COLS * MAX_ROWS;
    localparam int GAW    = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;
    localparam int LAW    = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;

    // configuration registers
    logic [6:0] cols_reg;
    logic [5:0] rows_reg;
    logic [7:0] limit_reg;

    // console state
    logic [6:0] col_reg, col_next;
    logic [5:0] row_reg, row_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] edit_reg, edit_next;
    logic [GAW-1:0] clr_addr_reg, clr_addr_next;
    logic [7:0] idx_reg, idx_next;

    // latched input beat
    logic [2:0] func_reg;
    logic [7:0] char_reg;
    logic [6:0] rcol_reg;
    logic [4:0] rrow_reg;
    logic [6:0] ridx_reg;
    logic       ign_reg;

    // result registers
    logic       out_valid_reg;
    logic [6:0] o_col_reg;
    logic [4:0] o_row_reg;
    logic [7:0] o_len_reg;
    logic [7:0] o_edit_reg;
    logic [7:0] o_cell_reg;
    logic [7:0] o_line_reg;
    logic       o_ign_reg;

    // active sizes
    logic [6:0] acols;
    logic [5:0] arows;
    logic [7:0] alimit;

    // cursor moves
    logic [5:0] down_row;
    logic [6:0] right_col, left_col;
    logic [5:0] right_row, left_row;
    logic [GAW-1:0] cur_addr, left_addr, cell_addr;
    logic       is_insert, ins_refuse, del_refuse, cell_ok, line_ok;

    // ram ports
    logic           g_we, g_re;
    logic [GAW-1:0] g_waddr;
    logic [7:0]     g_wdata, g_rdata;
    logic           l_we, l_re;
    logic [LAW-1:0] l_waddr, l_raddr;
    logic [7:0]     l_wdata, l_rdata;

    // clamp the configuration to the storage
    always_comb
    begin
        if (cols_reg == 7'd0)
            acols = 7'd1;
        else if (32'(cols_reg) > MAX_COLS)
            acols = 7'(MAX_COLS);
        else
            acols = cols_reg;
        if (rows_reg == 6'd0)
            arows = 6'd1;
        else if (32'(rows_reg) > MAX_ROWS)
            arows = 6'(MAX_ROWS);
        else
            arows = rows_reg;
        if (32'(limit_reg) > MAX_LINE)
            alimit = 8'(MAX_LINE);
        else
            alimit = limit_reg;
    end

    // neighbor cursor positions with wrap
    always_comb
    begin
        down_row = (row_reg >= arows - 6'd1) ? 6'd0 : row_reg + 6'd1;
        if (col_reg >= acols - 7'd1)
        begin
            right_col = 7'd0;
            right_row = down_row;
        end
        else
        begin
            right_col = col_reg + 7'd1;
            right_row = row_reg;
        end
        if (col_reg == 7'd0)
        begin
            left_col = acols - 7'd1;
            left_row = (row_reg == 6'd0) ? arows - 6'd1 : row_reg - 6'd1;
        end
        else
        begin
            left_col = col_reg - 7'd1;
            left_row = row_reg;
        end
        cur_addr  = GAW'(32'(row_reg) * MAX_COLS + 32'(col_reg));
        left_addr = GAW'(32'(left_row) * MAX_COLS + 32'(left_col));
        cell_addr = GAW'(32'(rrow_reg) * MAX_COLS + 32'(rcol_reg));
        cell_ok   = (32'(rcol_reg) < MAX_COLS) && (32'(rrow_reg) < MAX_ROWS);
        line_ok   = (32'(ridx_reg) < MAX_LINE) && ({1'b0, ridx_reg} < len_reg);
    end

    // refusal checks on the current line
    assign ins_refuse = (len_reg >= alimit) || (edit_reg > len_reg);
    assign del_refuse = (len_reg == 8'd0) || (edit_reg == 8'd0) || (edit_reg > len_reg);
    assign is_insert  = (func_reg == tcle_pkg::FUNC_INSERT);

    // next state of the console and the store ports
    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        len_next      = len_reg;
        edit_next     = edit_reg;
        clr_addr_next = clr_addr_reg;
        idx_next      = idx_reg;
        g_we          = 1'b0;
        g_waddr       = cur_addr;
        g_wdata       = tcle_pkg::CHAR_SPACE;
        g_re          = cmd.rd_issue;
        l_we          = 1'b0;
        l_waddr       = LAW'(edit_reg);
        l_wdata       = char_reg;
        l_re          = cmd.rd_issue | cmd.shift_rd;
        l_raddr       = LAW'(ridx_reg);

        // grid clearing pass
        if (cmd.clr_init)
        begin
            col_next      = 7'd0;
            row_next      = 6'd0;
            len_next      = 8'd0;
            edit_next     = 8'd0;
            clr_addr_next = '0;
        end
        if (cmd.clr_step)
        begin
            g_we          = 1'b1;
            g_waddr       = clr_addr_reg;
            clr_addr_next = (32'(clr_addr_reg) == GDEPTH - 1) ? '0 : clr_addr_reg + 1'b1;
        end

        // line shift, one entry per read and write pair
        if (cmd.shift_init)
        begin
            idx_next = is_insert ? len_reg : edit_reg - 8'd1;
        end
        if (cmd.shift_rd)
        begin
            l_raddr = is_insert ? LAW'(idx_reg - 8'd1) : LAW'(idx_reg + 8'd1);
        end
        if (cmd.shift_wr)
        begin
            l_we     = 1'b1;
            l_waddr  = LAW'(idx_reg);
            l_wdata  = l_rdata;
            idx_next = is_insert ? idx_reg - 8'd1 : idx_reg + 8'd1;
        end

        // per-function register update and grid write
        if (cmd.finish && !ign_reg)
        begin
            case (func_reg)
                tcle_pkg::FUNC_WRITE, tcle_pkg::FUNC_INSERT:
                begin
                    if (is_insert)
                    begin
                        l_we      = 1'b1;
                        edit_next = edit_reg + 8'd1;
                        len_next  = len_reg + 8'd1;
                    end
                    if (char_reg == tcle_pkg::CHAR_NEWLINE)
                    begin
                        col_next = 7'd0;
                        row_next = down_row;
                    end
                    else if (char_reg != tcle_pkg::CHAR_NUL)
                    begin
                        g_we     = 1'b1;
                        g_wdata  = char_reg;
                        col_next = right_col;
                        row_next = right_row;
                    end
                end
                tcle_pkg::FUNC_BKSP, tcle_pkg::FUNC_DELETE:
                begin
                    if (func_reg == tcle_pkg::FUNC_DELETE)
                    begin
                        edit_next = edit_reg - 8'd1;
                        len_next  = len_reg - 8'd1;
                    end
                    g_we     = 1'b1;
                    g_waddr  = left_addr;
                    col_next = left_col;
                    row_next = left_row;
                end
                tcle_pkg::FUNC_ACCEPT:
                begin
                    len_next  = 8'd0;
                    edit_next = 8'd0;
                    col_next  = 7'd0;
                    row_next  = down_row;
                end
                default:
                begin
                end
            endcase
        end

        // result read of one cell and one line entry
        if (cmd.rd_issue)
        begin
            l_raddr = LAW'(ridx_reg);
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg  <= 7'd80;
            rows_reg  <= 6'd32;
            limit_reg <= 8'd128;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tcle_pkg::REG_COLUMNS: cols_reg  <= cfg_wdata[6:0];
                tcle_pkg::REG_ROWS:    rows_reg  <= cfg_wdata[5:0];
                tcle_pkg::REG_LIMIT:   limit_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // console control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= 7'd0;
            row_reg       <= 6'd0;
            len_reg       <= 8'd0;
            edit_reg      <= 8'd0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            len_reg       <= len_next;
            edit_reg      <= edit_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= cmd.capture | (out_valid_reg & out_stall);
        end
    end

    // input beat, shift index and result payload
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.load)
        begin
            func_reg <= func;
            char_reg <= char_code;
            rcol_reg <= read_column;
            rrow_reg <= read_row;
            ridx_reg <= read_index;
            ign_reg  <= ((func == tcle_pkg::FUNC_INSERT) && ins_refuse) ||
                        ((func == tcle_pkg::FUNC_DELETE) && del_refuse);
        end
        if (cmd.capture)
        begin
            o_col_reg  <= col_reg;
            o_row_reg  <= row_reg[4:0];
            o_len_reg  <= len_reg;
            o_edit_reg <= edit_reg;
            o_cell_reg <= cell_ok ? g_rdata : tcle_pkg::CHAR_SPACE;
            o_line_reg <= line_ok ? l_rdata : tcle_pkg::CHAR_NUL;
            o_ign_reg  <= ign_reg;
        end
    end

    // grid and line stores
    tcle_ram #(.WIDTH(8), .DEPTH(GDEPTH)) u_grid (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .re    (g_re),
        .raddr (cell_addr),
        .rdata (g_rdata)
    );

    tcle_ram #(.WIDTH(8), .DEPTH(MAX_LINE)) u_line (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .re    (l_re),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    // status toward the controller
    always_comb
    begin
        status.func       = func_reg;
        status.ign        = ign_reg;
        status.clr_last   = (32'(clr_addr_reg) == GDEPTH - 1);
        status.shift_more = is_insert ? (idx_reg > edit_reg)
                                      : ({1'b0, idx_reg} + 9'd1 < {1'b0, len_reg});
        status.out_free   = !out_valid_reg || !out_stall;
    end

    assign out_valid     = out_valid_reg;
    assign cursor_column = o_col_reg;
    assign cursor_row    = o_row_reg;
    assign line_length   = o_len_reg;
    assign edit_position = o_edit_reg;
    assign cell_char     = o_cell_reg;
    assign line_char     = o_line_reg;
    assign ignored       = o_ign_reg;

endmodule

### rtl/text_console_line_editor.sv
// top level of the text console line editor
// depends on tcle_pkg, tcle_ctrl, tcle_dpath and tcle_ram
`timescale 1ns / 1ps

// Usage:
// An input beat (in_valid, not in_stall) carries func, char_code and the read
// coordinates; every beat returns exactly one result beat on out_valid, held
// until out_stall is low. Configuration is written through cfg_we, cfg_index
// and cfg_wdata while no beat is in flight.
// A write, backspace, accept, read only or refused edit passes through the
// dispatch, finish, read and capture states; in_stall stays high until the
// capture, so a new beat is taken only after the previous one is finished.
// An insert or delete that goes through first shifts line_length -
// edit_position entries (counted before the step), each with a read and a
// write; the shift walks the line memory through its single read port.
// A clear sweeps the grid memory at one cell per cycle in place of the update
// step, then goes on to the read and capture of its result.
// After reset the same sweep over all MAX_COLS * MAX_ROWS cells fills the grid
// with spaces; in_stall stays high until it ends.
// A new beat is taken while the previous result still waits; if the receiver
// stalls, the following result waits in its final step with the stores held.

module text_console_line_editor #(
    parameter int MAX_COLS = 80,
    parameter int MAX_ROWS = 32,
    parameter int MAX_LINE = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] func,
    input  logic [7:0] char_code,
    input  logic [6:0] read_column,
    input  logic [4:0] read_row,
    input  logic [6:0] read_index,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [6:0] cursor_column,
    output logic [4:0] cursor_row,
    output logic [7:0] line_length,
    output logic [7:0] edit_position,
    output logic [7:0] cell_char,
    output logic [7:0] line_char,
    output logic       ignored
);

    tcle_pkg::tcle_cmd_t    cmd;
    tcle_pkg::tcle_status_t status;

    // sequencer
    tcle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // registers and stores
    tcle_dpath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .MAX_LINE (MAX_LINE)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .func          (func),
        .char_code     (char_code),
        .read_column   (read_column),
        .read_row      (read_row),
        .read_index    (read_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cursor_column (cursor_column),
        .cursor_row    (cursor_row),
        .line_length   (line_length),
        .edit_position (edit_position),
        .cell_char     (cell_char),
        .line_char     (line_char),
        .ignored       (ignored)
    );

endmodule

### rtl/tcle_checker.sv
// port-level checks of the text console line editor, bound to the top level
// depends on text_console_line_editor
`timescale 1ns / 1ps

module tcle_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] line_length,
    input logic [7:0] edit_position,
    input logic [6:0] cursor_column
);

    // a beat taken keeps the input closed while it is worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after an accepted beat");

    // edit point never lies past the end of the line
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (edit_position <= line_length))
        else $error("edit position beyond line length");

    // stalled result stays
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(line_length) &&
                                      $stable(cursor_column)))
        else $error("stalled result changed");

    // no result just as reset is released
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("result right after reset");

endmodule

bind text_console_line_editor tcle_checker u_tcle_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .line_length   (line_length),
    .edit_position (edit_position),
    .cursor_column (cursor_column)
);

### test/text_console_line_editor_tb.sv
// testbench of the text console line editor: directed and random edits, config sweeps
// depends on tcle_pkg and the text_console_line_editor rtl; self checking, no files
`timescale 1ns / 1ps

module text_console_line_editor_tb;

    localparam int GRID_COLS  = 80;
    localparam int GRID_ROWS  = 32;
    localparam int LINE_SIZE  = 128;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [6:0] cursor_column;
        logic [4:0] cursor_row;
        logic [7:0] line_length;
        logic [7:0] edit_position;
        logic [7:0] cell_char;
        logic [7:0] line_char;
        logic       ignored;
    } console_view_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = tcle_pkg::REG_COLUMNS;
    logic [7:0] cfg_wdata = 8'd0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [2:0] func = tcle_pkg::FUNC_READ;
    logic [7:0] char_code = 8'd0;
    logic [6:0] read_column = 7'd0;
    logic [4:0] read_row = 5'd0;
    logic [6:0] read_index = 7'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [6:0] cursor_column;
    logic [4:0] cursor_row;
    logic [7:0] line_length;
    logic [7:0] edit_position;
    logic [7:0] cell_char;
    logic [7:0] line_char;
    logic       ignored;

    // shadow copy of the console state
    logic [7:0] grid_shadow [GRID_ROWS*GRID_COLS];
    logic [7:0] line_shadow [LINE_SIZE];
    int cur_col, cur_row, edit_pos, line_len;
    int cols_setting, rows_setting, limit_setting;

    console_view_t pending_views[$];
    int mismatches = 0;
    int beats_sent = 0;
    int beats_checked = 0;
    int refused_edits = 0;
    int clears_sent = 0;
    int idle_pct = 12;
    int quiet_cycles = 0;
    bit accepted_any;

    text_console_line_editor dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .char_code(char_code), .read_column(read_column),
        .read_row(read_row), .read_index(read_index),
        .out_valid(out_valid), .out_stall(out_stall),
        .cursor_column(cursor_column), .cursor_row(cursor_row),
        .line_length(line_length), .edit_position(edit_position),
        .cell_char(cell_char), .line_char(line_char), .ignored(ignored)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // effective sizes after clamping
    function automatic int active_cols();
        int c;
        c = cols_setting;
        if (c < 1) c = 1;
        if (c > GRID_COLS) c = GRID_COLS;
        return c;
    endfunction

    function automatic int active_rows();
        int r;
        r = rows_setting;
        if (r < 1) r = 1;
        if (r > GRID_ROWS) r = GRID_ROWS;
        return r;
    endfunction

    function automatic void cursor_down();
        if (cur_row >= active_rows() - 1) cur_row = 0;
        else cur_row++;
    endfunction

    function automatic void cursor_forward();
        if (cur_col >= active_cols() - 1)
        begin
            cur_col = 0;
            cursor_down();
        end
        else cur_col++;
    endfunction

    function automatic void cursor_newline();
        cur_col = 0;
        cursor_down();
    endfunction

    function automatic void put_glyph(logic [7:0] ch);
        if (ch == tcle_pkg::CHAR_NEWLINE) cursor_newline();
        else if (ch != tcle_pkg::CHAR_NUL)
        begin
            grid_shadow[cur_row*GRID_COLS + cur_col] = ch;
            cursor_forward();
        end
    endfunction

    // step left with wrap, then blank the cell
    function automatic void erase_glyph();
        if (cur_col < 1)
        begin
            cur_col = active_cols() - 1;
            if (cur_row < 1) cur_row = active_rows() - 1;
            else cur_row--;
        end
        else cur_col--;
        grid_shadow[cur_row*GRID_COLS + cur_col] = tcle_pkg::CHAR_SPACE;
    endfunction

    function automatic void blank_console();
        foreach (grid_shadow[k]) grid_shadow[k] = tcle_pkg::CHAR_SPACE;
        foreach (line_shadow[k]) line_shadow[k] = tcle_pkg::CHAR_NUL;
        cur_col = 0;
        cur_row = 0;
        edit_pos = 0;
        line_len = 0;
    endfunction

    // apply one beat to the shadow state and return what the block must report
    function automatic console_view_t console_step(logic [2:0] f, logic [7:0] ch,
            logic [6:0] rc, logic [4:0] rr, logic [6:0] ri);
        console_view_t v;
        int lim;
        logic refused;
        refused = 1'b0;
        lim = (limit_setting > LINE_SIZE) ? LINE_SIZE : limit_setting;
        case (f)
            tcle_pkg::FUNC_WRITE: put_glyph(ch);
            tcle_pkg::FUNC_BKSP: erase_glyph();
            tcle_pkg::FUNC_CLEAR: blank_console();
            tcle_pkg::FUNC_INSERT:
            begin
                if (line_len >= lim || edit_pos > line_len) refused = 1'b1;
                else
                begin
                    for (int i = line_len; i > edit_pos; i--) line_shadow[i] = line_shadow[i-1];
                    line_shadow[edit_pos] = ch;
                    edit_pos++;
                    line_len++;
                    put_glyph(ch);
                end
            end
            tcle_pkg::FUNC_DELETE:
            begin
                if (line_len < 1 || edit_pos < 1 || edit_pos > line_len) refused = 1'b1;
                else
                begin
                    for (int i = edit_pos - 1; i + 1 < line_len; i++)
                        line_shadow[i] = line_shadow[i+1];
                    line_shadow[line_len-1] = tcle_pkg::CHAR_NUL;
                    edit_pos--;
                    line_len--;
                    erase_glyph();
                end
            end
            tcle_pkg::FUNC_ACCEPT:
            begin
                foreach (line_shadow[k]) line_shadow[k] = tcle_pkg::CHAR_NUL;
                edit_pos = 0;
                line_len = 0;
                cursor_newline();
            end
            default: ;
        endcase
        v.cursor_column = cur_col[6:0];
        v.cursor_row = cur_row[4:0];
        v.line_length = line_len[7:0];
        v.edit_position = edit_pos[7:0];
        v.cell_char = (rc < GRID_COLS && rr < GRID_ROWS) ?
                      grid_shadow[rr*GRID_COLS + rc] : tcle_pkg::CHAR_SPACE;
        v.line_char = (ri < line_len) ? line_shadow[ri] : tcle_pkg::CHAR_NUL;
        v.ignored = refused;
        return v;
    endfunction

    // one input beat, with a random gap ahead of it
    task automatic send_beat(logic [2:0] f, logic [7:0] ch, logic [6:0] rc,
            logic [4:0] rr, logic [6:0] ri);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        char_code <= ch;
        read_column <= rc;
        read_row <= rr;
        read_index <= ri;
        do @(posedge clk); while (in_stall);
        pending_views.push_back(console_step(f, ch, rc, rr, ri));
        beats_sent++;
        if (f == tcle_pkg::FUNC_CLEAR) clears_sent++;
    endtask

    // random read coordinates, mostly inside the active area
    task automatic send_op(logic [2:0] f, logic [7:0] ch);
        logic [6:0] rc;
        logic [4:0] rr;
        if ($urandom_range(3) == 0)
        begin
            rc = 7'($urandom);
            rr = 5'($urandom);
        end
        else
        begin
            rc = 7'($urandom_range(active_cols() - 1));
            rr = 5'($urandom_range(active_rows() - 1));
        end
        send_beat(f, ch, rc, rr, $urandom_range(3) == 0 ? 7'($urandom) :
                  7'($urandom_range(line_len > 0 ? line_len - 1 : 0)));
    endtask

    // register writes only once the block has drained
    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        in_valid <= 1'b0;
        while (pending_views.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            tcle_pkg::REG_COLUMNS: cols_setting = val & 8'h7F;
            tcle_pkg::REG_ROWS: rows_setting = val & 8'h3F;
            default: limit_setting = val;
        endcase
    endtask

    task automatic set_geometry(int c, int r, int l);
        write_reg(tcle_pkg::REG_COLUMNS, 8'(c));
        write_reg(tcle_pkg::REG_ROWS, 8'(r));
        write_reg(tcle_pkg::REG_LIMIT, 8'(l));
    endtask

    function automatic logic [7:0] random_char();
        case ($urandom_range(9))
            0: return tcle_pkg::CHAR_NEWLINE;
            1: return tcle_pkg::CHAR_NUL;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        send_beat(tcle_pkg::FUNC_READ, 8'h00, 7'd0, 5'd0, 7'd0);
        send_beat(tcle_pkg::FUNC_WRITE, 8'h41, 7'd0, 5'd0, 7'd0);
        send_beat(tcle_pkg::FUNC_WRITE, 8'hFF, 7'd1, 5'd0, 7'd0);
        send_beat(tcle_pkg::FUNC_WRITE, tcle_pkg::CHAR_NUL, 7'd2, 5'd0, 7'd0);
        send_beat(tcle_pkg::FUNC_WRITE, tcle_pkg::CHAR_NEWLINE, 7'd0, 5'd0, 7'd0);
        send_beat(tcle_pkg::FUNC_BKSP, 8'h00, 7'd79, 5'd0, 7'd0);
        send_beat(tcle_pkg::FUNC_DELETE, 8'h00, 7'd0, 5'd0, 7'd0);
        send_beat(tcle_pkg::FUNC_INSERT, 8'h61, 7'd0, 5'd0, 7'd0);
        send_beat(tcle_pkg::FUNC_INSERT, tcle_pkg::CHAR_NEWLINE, 7'd1, 5'd0, 7'd1);
        send_beat(tcle_pkg::FUNC_INSERT, tcle_pkg::CHAR_NUL, 7'd0, 5'd1, 7'd2);
        send_beat(tcle_pkg::FUNC_INSERT, 8'h80, 7'd0, 5'd1, 7'd3);
        send_beat(tcle_pkg::FUNC_DELETE, 8'h00, 7'd0, 5'd1, 7'd2);
        send_beat(tcle_pkg::FUNC_READ, 8'h00, 7'd127, 5'd31, 7'd127);
        send_beat(tcle_pkg::FUNC_READ, 8'h00, 7'd79, 5'd31, 7'd1);
        send_beat(3'd7, 8'hAA, 7'd80, 5'd0, 7'd0);
        send_beat(tcle_pkg::FUNC_ACCEPT, 8'h00, 7'd0, 5'd0, 7'd0);
        send_beat(tcle_pkg::FUNC_BKSP, 8'h00, 7'd79, 5'd1, 7'd0);
        send_beat(tcle_pkg::FUNC_CLEAR, 8'h00, 7'd0, 5'd0, 7'd0);
        send_beat(tcle_pkg::FUNC_BKSP, 8'h00, 7'd79, 5'd31, 7'd0);
    endtask

    // fill the line to the limit and one past, then empty it again
    task automatic test_line_full(int lim);
        set_geometry(80, 32, lim);
        for (int i = 0; i <= (lim > LINE_SIZE ? LINE_SIZE : lim); i++)
            send_op(tcle_pkg::FUNC_INSERT, 8'($urandom_range(32, 126)));
        while (line_len > 0) send_op(tcle_pkg::FUNC_DELETE, 8'h00);
        send_op(tcle_pkg::FUNC_DELETE, 8'h00);
    endtask

    // shrink the grid while the cursor sits far out, then keep writing
    task automatic test_cursor_outside();
        set_geometry(80, 32, 128);
        for (int i = 0; i < 20; i++) send_op(tcle_pkg::FUNC_WRITE, tcle_pkg::CHAR_NEWLINE);
        for (int i = 0; i < 50; i++) send_op(tcle_pkg::FUNC_WRITE, 8'h7E);
        set_geometry(0, 0, 0);
        for (int i = 0; i < 4; i++) send_op(tcle_pkg::FUNC_WRITE, 8'(8'h30 + i));
        send_op(tcle_pkg::FUNC_BKSP, 8'h00);
        send_op(tcle_pkg::FUNC_INSERT, 8'h31);
        set_geometry(127, 63, 255);
        for (int i = 0; i < 6; i++) send_op(tcle_pkg::FUNC_BKSP, 8'h00);
    endtask

    // random mix of inserts, deletes, writes, backspaces, accepts, reads and unused codes; rare clears
    task automatic test_random(int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(199);
            if (pick < 60) send_op(tcle_pkg::FUNC_INSERT, random_char());
            else if (pick < 90) send_op(tcle_pkg::FUNC_DELETE, 8'h00);
            else if (pick < 130) send_op(tcle_pkg::FUNC_WRITE, random_char());
            else if (pick < 150) send_op(tcle_pkg::FUNC_BKSP, 8'h00);
            else if (pick < 162) send_op(tcle_pkg::FUNC_ACCEPT, 8'h00);
            else if (pick < 164) send_op(tcle_pkg::FUNC_CLEAR, 8'h00);
            else if (pick < 190) send_op(tcle_pkg::FUNC_READ, 8'($urandom));
            else send_op(3'd7, 8'($urandom));
        end
    endtask

    // receiver stalls at random
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < idle_pct);
    end

    // compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        console_view_t seen, want;
        if (rst_n && out_valid && !out_stall)
        begin
            seen = '{cursor_column, cursor_row, line_length, edit_position,
                     cell_char, line_char, ignored};
            beats_checked++;
            if (pending_views.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", seen);
            end
            else
            begin
                want = pending_views.pop_front();
                if (seen.ignored) refused_edits++;
                if (seen !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat %0d mismatch: expected %p got %p",
                                 beats_checked, want, seen);
                end
            end
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge clk)
    begin
        accepted_any = (in_valid && !in_stall) || (out_valid && !out_stall);
        if (!rst_n || accepted_any) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        cols_setting = 80;
        rows_setting = 32;
        limit_setting = 128;
        blank_console();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        do @(posedge clk); while (in_stall);

        test_directed();
        test_line_full(0);
        test_line_full(5);
        test_line_full(255);
        test_cursor_outside();
        set_geometry(1, 1, 128);
        test_random(200);
        set_geometry(7, 3, 9);
        test_random(300);
        idle_pct = 0;
        set_geometry(80, 32, 128);
        test_random(300);
        idle_pct = 12;
        set_geometry(127, 63, 200);
        test_random(250);
        set_geometry(13, 32, 1);
        test_random(200);
        set_geometry(80, 5, 40);
        test_random(250);

        in_valid <= 1'b0;
        while (pending_views.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("sent %0d beats (%0d clears), checked %0d results, %0d refused edits",
                 beats_sent, clears_sent, beats_checked, refused_edits);
        $display("geometry and line limit swept through their extremes; %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
